@@ sv/mab_pkg.sv @@
`timescale 1ns / 1ps

package mab_pkg;

    localparam int HISTORY_DEF     = 256;
    localparam int AVG_PER_RES_DEF = 4;

    localparam int PRICE_W      = 24;
    localparam int FRAC_W       = 8;
    localparam int AVG_W        = PRICE_W + FRAC_W;
    localparam int GROUP_W      = 6;
    localparam int REPORT_SLOTS = 4;

    // widest ring index over the supported history range
    localparam int SLOT_MAX_W = 10;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic                  warm;
        logic [SLOT_MAX_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_MAX_W-1:0] addr;
        logic [PRICE_W-1:0]    data;
    } ring_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic full_done;
    } back_stat_t;

endpackage

@@ sv/mab_front.sv @@
`timescale 1ns / 1ps

module mab_front #(
    parameter int HISTORY = mab_pkg::HISTORY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       price_valid,
    output logic                       price_stall,
    input  logic [mab_pkg::PRICE_W-1:0] price,
    input  mab_pkg::queue_stat_t       q_stat,
    input  mab_pkg::back_stat_t        b_stat,
    output logic                       q_push,
    output mab_pkg::cmd_t              q_cmd,
    output mab_pkg::ring_wr_t          ring_wr
);
    import mab_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY);
    localparam int SEEN_W = $clog2(HISTORY + 1);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              busy_reg, busy_next;
    logic              accept;
    logic              warm;

    // a full word reads the whole ring, so no new sample may land until it is done
    assign price_stall = q_stat.full | busy_reg;
    assign accept      = price_valid & ~price_stall;
    assign warm        = (seen_reg != SEEN_W'(HISTORY));

    always_comb
    begin
        slot_next = slot_reg;
        seen_next = seen_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            slot_next = (slot_reg == SLOT_W'(HISTORY - 1)) ? '0 : slot_reg + 1'b1;
            if (warm)
            begin
                seen_next = seen_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (b_stat.full_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            seen_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            seen_reg <= seen_next;
            busy_reg <= busy_next;
        end
    end

    assign q_push       = accept;
    assign q_cmd.warm   = warm;
    assign q_cmd.slot   = SLOT_MAX_W'(slot_reg);
    assign ring_wr.en   = accept;
    assign ring_wr.addr = SLOT_MAX_W'(slot_reg);
    assign ring_wr.data = price;

endmodule

@@ sv/mab_queue.sv @@
`timescale 1ns / 1ps

module mab_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mab_pkg::cmd_t        cmd_in,
    input  logic                 pop,
    output mab_pkg::cmd_t        cmd_out,
    output mab_pkg::queue_stat_t stat
);
    import mab_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             ent_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out    = ent_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

@@ sv/mab_back.sv @@
`timescale 1ns / 1ps

module mab_back #(
    parameter int HISTORY     = mab_pkg::HISTORY_DEF,
    parameter int AVG_PER_RES = mab_pkg::AVG_PER_RES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mab_pkg::queue_stat_t        q_stat,
    input  mab_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    input  mab_pkg::ring_wr_t           ring_wr,
    output mab_pkg::back_stat_t         b_stat,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        ready_res,
    output logic [mab_pkg::GROUP_W-1:0] group,
    output logic [mab_pkg::AVG_W-1:0]   avg_first,
    output logic [mab_pkg::AVG_W-1:0]   avg_second,
    output logic [mab_pkg::AVG_W-1:0]   avg_third,
    output logic [mab_pkg::AVG_W-1:0]   avg_fourth,
    output logic                        last
);
    import mab_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY);
    localparam int LEN_W  = $clog2(HISTORY + 1);
    localparam int BASE_W = LEN_W + 1;
    localparam int SUM_W  = PRICE_W + LEN_W;
    localparam int GROUPS = (HISTORY + AVG_PER_RES - 1) / AVG_PER_RES;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int K_W    = (AVG_PER_RES > 1) ? $clog2(AVG_PER_RES) : 1;
    localparam int DCNT_W = $clog2(AVG_W);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_ACC  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [GRP_W-1:0]    group_reg, group_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                ready_res_reg, ready_res_next;
    logic                last_reg, last_next;

    logic [SUM_W-1:0]    snap_reg [REPORT_SLOTS];
    logic [SUM_W-1:0]    snap_next [REPORT_SLOTS];
    logic [LEN_W-1:0]    rem_reg [REPORT_SLOTS];
    logic [LEN_W-1:0]    rem_next [REPORT_SLOTS];
    logic [AVG_W-1:0]    quo_reg [REPORT_SLOTS];
    logic [AVG_W-1:0]    quo_next [REPORT_SLOTS];
    logic [AVG_W-1:0]    avg_reg [REPORT_SLOTS];
    logic [AVG_W-1:0]    avg_next [REPORT_SLOTS];

    logic [PRICE_W-1:0]  ring_mem [HISTORY];
    logic [PRICE_W-1:0]  rd_data_reg;

    logic [BASE_W-1:0]   lane_len [REPORT_SLOTS];
    logic                lane_ok [REPORT_SLOTS];
    logic [LEN_W:0]      trial [REPORT_SLOTS];
    logic                trial_ge [REPORT_SLOTS];
    logic [LEN_W-1:0]    step_rem [REPORT_SLOTS];
    logic [AVG_W-1:0]    step_quo [REPORT_SLOTS];
    logic                end_group;

    always_ff @(posedge clk)
    begin
        if (ring_wr.en)
        begin
            ring_mem[ring_wr.addr[SLOT_W-1:0]] <= ring_wr.data;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // one restoring step per lane; the remainder always stays below the window length
    always_comb
    begin
        for (int j = 0; j < REPORT_SLOTS; j++)
        begin
            lane_len[j] = base_reg + BASE_W'(j + 1);
            lane_ok[j]  = (j < AVG_PER_RES) && (lane_len[j] <= BASE_W'(HISTORY));
            trial[j]    = {rem_reg[j], quo_reg[j][AVG_W-1]};
            trial_ge[j] = (trial[j] >= {1'b0, lane_len[j][LEN_W-1:0]});
            step_rem[j] = trial_ge[j] ? LEN_W'(trial[j] - {1'b0, lane_len[j][LEN_W-1:0]})
                                      : trial[j][LEN_W-1:0];
            step_quo[j] = {quo_reg[j][AVG_W-2:0], trial_ge[j]};
        end
    end

    assign end_group = (k_reg == K_W'(AVG_PER_RES - 1))
                    || ((base_reg + BASE_W'(k_reg) + BASE_W'(1)) == BASE_W'(HISTORY));

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        group_next     = group_reg;
        acc_next       = acc_reg;
        dcnt_next      = dcnt_reg;
        ready_res_next = ready_res_reg;
        last_next      = last_reg;
        snap_next      = snap_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        avg_next       = avg_reg;
        q_pop          = 1'b0;
        b_stat.full_done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    group_next = '0;
                    if (q_cmd.warm)
                    begin
                        ready_res_next = 1'b0;
                        last_next      = 1'b1;
                        for (int j = 0; j < REPORT_SLOTS; j++)
                        begin
                            avg_next[j] = '0;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ready_res_next = 1'b1;
                        last_next      = 1'b0;
                        base_next      = '0;
                        k_next         = '0;
                        acc_next       = '0;
                        rd_ptr_next    = q_cmd.slot[SLOT_W-1:0];
                        state_next     = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + SUM_W'(rd_data_reg);
                for (int j = 0; j < REPORT_SLOTS; j++)
                begin
                    if ((j < AVG_PER_RES) && (k_reg == K_W'(j)))
                    begin
                        snap_next[j] = acc_next;
                    end
                end
                // walk backward from the newest sample
                rd_ptr_next = (rd_ptr_reg == '0) ? SLOT_W'(HISTORY - 1) : rd_ptr_reg - 1'b1;
                if (end_group)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_LOAD:
            begin
                // top bits of sum*256 seed the remainder, the rest shifts through quo
                for (int j = 0; j < REPORT_SLOTS; j++)
                begin
                    rem_next[j] = snap_reg[j][SUM_W-1:PRICE_W];
                    quo_next[j] = {snap_reg[j][PRICE_W-1:0], FRAC_W'(0)};
                end
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = step_rem;
                quo_next  = step_quo;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(AVG_W - 1))
                begin
                    for (int j = 0; j < REPORT_SLOTS; j++)
                    begin
                        avg_next[j] = lane_ok[j] ? step_quo[j] : '0;
                    end
                    last_next  = (group_reg == GRP_W'(GROUPS - 1));
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    if (last_reg)
                    begin
                        b_stat.full_done = ready_res_reg;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        base_next  = base_reg + BASE_W'(AVG_PER_RES);
                        group_next = group_reg + 1'b1;
                        k_next     = '0;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            base_reg      <= '0;
            group_reg     <= '0;
            acc_reg       <= '0;
            dcnt_reg      <= '0;
            ready_res_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            group_reg     <= group_next;
            acc_reg       <= acc_next;
            dcnt_reg      <= dcnt_next;
            ready_res_reg <= ready_res_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        avg_reg  <= avg_next;
    end

    assign result_valid = (state_reg == S_OUT);
    assign ready_res    = ready_res_reg;
    assign group        = GROUP_W'(group_reg);
    assign avg_first    = avg_reg[0];
    assign avg_second   = avg_reg[1];
    assign avg_third    = avg_reg[2];
    assign avg_fourth   = avg_reg[3];
    assign last         = last_reg;

endmodule

@@ sv/moving_average_bank_core.sv @@
`timescale 1ns / 1ps

// Moving-average bank: each price word is written into a ring of the last HISTORY samples.
// During the first HISTORY words the block returns one not-ready word with last set, offered
// once its command has passed the queue and a free engine has taken it. After that, each
// price word yields ceil(HISTORY/AVG_PER_RES) result words, one per group of window lengths,
// each carrying floor(sum*256/len) for up to four consecutive windows. For each group the
// engine walks the ring memory (one registered read and one add per sample), loads and runs
// the bit-serial dividers (one per reported window, run side by side) and then presents the
// output word; each word is first dispatched from the queue by the idle engine.
// A short command queue sits between the intake and the averaging engine; warm-up words can
// pile into it, but a full word holds off the next price word until its last result has been
// taken, since that word reads every ring entry.
module moving_average_bank_core #(
    parameter int HISTORY     = mab_pkg::HISTORY_DEF,
    parameter int AVG_PER_RES = mab_pkg::AVG_PER_RES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        price_valid,
    output logic                        price_stall,
    input  logic [mab_pkg::PRICE_W-1:0] price,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        ready_res,
    output logic [mab_pkg::GROUP_W-1:0] group,
    output logic [mab_pkg::AVG_W-1:0]   avg_first,
    output logic [mab_pkg::AVG_W-1:0]   avg_second,
    output logic [mab_pkg::AVG_W-1:0]   avg_third,
    output logic [mab_pkg::AVG_W-1:0]   avg_fourth,
    output logic                        last
);
    import mab_pkg::*;

    queue_stat_t q_stat;
    back_stat_t  b_stat;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;
    ring_wr_t    ring_wr;
    logic        q_push;
    logic        q_pop;

    mab_front #(
        .HISTORY (HISTORY)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_valid (price_valid),
        .price_stall (price_stall),
        .price       (price),
        .q_stat      (q_stat),
        .b_stat      (b_stat),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .ring_wr     (ring_wr)
    );

    mab_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .pop     (q_pop),
        .cmd_out (pop_cmd),
        .stat    (q_stat)
    );

    mab_back #(
        .HISTORY     (HISTORY),
        .AVG_PER_RES (AVG_PER_RES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .ring_wr      (ring_wr),
        .b_stat       (b_stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ready_res    (ready_res),
        .group        (group),
        .avg_first    (avg_first),
        .avg_second   (avg_second),
        .avg_third    (avg_third),
        .avg_fourth   (avg_fourth),
        .last         (last)
    );

endmodule

@@ sv/mab_checker.sv @@
`timescale 1ns / 1ps

module mab_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        price_valid,
    input logic                        price_stall,
    input logic [mab_pkg::PRICE_W-1:0] price,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic                        ready_res,
    input logic [mab_pkg::GROUP_W-1:0] group,
    input logic [mab_pkg::AVG_W-1:0]   avg_first,
    input logic [mab_pkg::AVG_W-1:0]   avg_second,
    input logic [mab_pkg::AVG_W-1:0]   avg_third,
    input logic [mab_pkg::AVG_W-1:0]   avg_fourth,
    input logic                        last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        price_valid && price_stall |=> price_valid && $stable(price))
        else $error("stalled price word changed or dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(group) && $stable(avg_first)
            && $stable(avg_fourth) && $stable(ready_res) && $stable(last))
        else $error("stalled result word changed");

    // warm-up words carry nothing but the last flag
    a_warm_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ready_res |-> last && (group == '0) && (avg_first == '0)
            && (avg_second == '0) && (avg_third == '0) && (avg_fourth == '0))
        else $error("warm-up word carries data");

    // window of one is the newest price scaled by 256
    a_single_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ready_res && (group == '0) |-> (avg_first[7:0] == 8'h00))
        else $error("single-sample average has fraction bits");

endmodule

bind moving_average_bank_core mab_checker u_mab_checker (.*);

@@ bench/moving_average_bank_core_tb.sv @@
`timescale 1ns / 1ps

module moving_average_bank_core_tb;
    import mab_pkg::*;

    localparam int HIST           = HISTORY_DEF;
    localparam int PER            = AVG_PER_RES_DEF;
    localparam int GROUPS         = (HIST + PER - 1) / PER;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD      = 500;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_WORDS   = 20;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic                               ready_res;
        logic [GROUP_W-1:0]                 grp;
        logic [REPORT_SLOTS-1:0][AVG_W-1:0] avg;
        logic                               last;
    } sma_word_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [9:0]         reps;
        logic               rand_price;
        logic               typed;
        sma_word_t          exp;
    } stim_row_t;

    // warm-up word: not ready, group 0, zero averages, last set
    localparam sma_word_t WARM_WORD = '{ready_res: 1'b0, grp: '0, avg: '0, last: 1'b1};
    localparam sma_word_t NO_WORD   = '0;

    localparam int PLAN_LEN = 15;
    localparam stim_row_t PLAN [PLAN_LEN] = '{
        '{24'h000000, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'hFFFFFF, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'hAAAAAA, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'h555555, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'h000001, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'h800000, 10'd1,   1'b0, 1'b1, WARM_WORD},
        '{24'h000000, 10'd200, 1'b1, 1'b1, WARM_WORD},
        // run of max prices closes the warm-up, so short windows hit the top average
        '{24'hFFFFFF, 10'd50,  1'b0, 1'b1, WARM_WORD},
        '{24'hFFFFFF, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'h000000, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'h000000, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'h000001, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'h7FFFFF, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'hAAAAAA, 10'd1,   1'b0, 1'b0, NO_WORD},
        '{24'h555555, 10'd1,   1'b0, 1'b0, NO_WORD}
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               price_valid  = 1'b0;
    logic               price_stall;
    logic [PRICE_W-1:0] price        = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               ready_res;
    logic [GROUP_W-1:0] group;
    logic [AVG_W-1:0]   avg_first;
    logic [AVG_W-1:0]   avg_second;
    logic [AVG_W-1:0]   avg_third;
    logic [AVG_W-1:0]   avg_fourth;
    logic               last;

    bit          calm        = 1'b0;
    int unsigned price_words = 0;
    int unsigned mismatches  = 0;
    sma_word_t   sma_due [$];

    // predictor state: price ring, write pointer, warm-up count
    logic [PRICE_W-1:0] hist [HIST];
    int unsigned        hist_wr   = 0;
    int unsigned        hist_fill = 0;

    moving_average_bank_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .price_valid  (price_valid),
        .price_stall  (price_stall),
        .price        (price),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ready_res    (ready_res),
        .group        (group),
        .avg_first    (avg_first),
        .avg_second   (avg_second),
        .avg_third    (avg_third),
        .avg_fourth   (avg_fourth),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Stores the price and, when queue_it is set, queues the words it causes.
    function automatic void predict_sma(input logic [PRICE_W-1:0] p, input bit queue_it);
        longint unsigned sums [HIST+1];
        int unsigned     newest;
        int unsigned     len;
        int unsigned     k;
        int unsigned     g;
        int unsigned     j;
        sma_word_t       w;
        newest       = hist_wr;
        hist[newest] = p;
        hist_wr      = (newest + 1) % HIST;
        if (hist_fill < HIST)
        begin
            hist_fill++;
            if (queue_it)
                sma_due.push_back(WARM_WORD);
        end
        else
        begin
            // running sums walking back from the newest sample
            sums[0] = 0;
            for (k = 1; k <= HIST; k++)
                sums[k] = sums[k-1] + hist[(newest + HIST - (k - 1)) % HIST];
            for (g = 0; g < GROUPS; g++)
            begin
                w           = '0;
                w.ready_res = 1'b1;
                w.grp       = GROUP_W'(g);
                w.last      = (g == GROUPS - 1);
                for (j = 0; j < REPORT_SLOTS; j++)
                begin
                    len = g * PER + j + 1;
                    if (j < PER && len <= HIST)
                        w.avg[j] = AVG_W'((sums[len] << FRAC_W) / len);
                end
                if (queue_it)
                    sma_due.push_back(w);
            end
        end
    endfunction

    task automatic send_price(input logic [PRICE_W-1:0] p, input bit typed,
                              input sma_word_t exp);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            price_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        price_valid <= 1'b1;
        price       <= p;
        do @(posedge clk); while (price_stall);
        price_words <= price_words + 1;
        predict_sma(p, !typed);
        if (typed)
            sma_due.push_back(exp);
    endtask

    initial
    begin : stimulus
        int unsigned        i;
        int unsigned        n;
        stim_row_t          row;
        logic [PRICE_W-1:0] p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (i = 0; i < PLAN_LEN; i++)
        begin
            row = PLAN[i];
            for (n = 0; n < row.reps; n++)
            begin
                p = row.rand_price ? PRICE_W'($urandom) : row.price;
                send_price(p, row.typed, row.exp);
            end
        end
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            case ($urandom_range(0, 9))
                0:       p = '0;
                1:       p = '1;
                2:       p = PRICE_W'($urandom_range(0, 255));
                default: p = PRICE_W'($urandom);
            endcase
            send_price(p, 1'b0, NO_WORD);
        end
        price_valid <= 1'b0;
        while (sma_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && sma_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus two long holds (warm-up, then full words)
    initial
    begin : result_side
        int unsigned stall_left;
        int unsigned holds;
        stall_left = 0;
        holds      = 0;
        forever
        begin
            @(posedge clk);
            if ((holds == 0 && price_words >= 60) || (holds == 1 && price_words >= HIST + 4))
            begin
                holds++;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = idle_gap();
            end
        end
    end

    initial
    begin : calm_phases
        forever
        begin
            repeat ($urandom_range(200, 2000)) @(posedge clk);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : result_check
        sma_word_t got;
        sma_word_t want;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                got.ready_res = ready_res;
                got.grp       = group;
                got.avg[0]    = avg_first;
                got.avg[1]    = avg_second;
                got.avg[2]    = avg_third;
                got.avg[3]    = avg_fourth;
                got.last      = last;
                if (sma_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected word: ready=%0d grp=%0d avg=%h %h %h %h last=%0d",
                                 got.ready_res, got.grp, got.avg[0], got.avg[1],
                                 got.avg[2], got.avg[3], got.last);
                end
                else
                begin
                    want = sma_due.pop_front();
                    if (got.ready_res !== want.ready_res || got.grp !== want.grp
                        || got.avg[0] !== want.avg[0] || got.avg[1] !== want.avg[1]
                        || got.avg[2] !== want.avg[2] || got.avg[3] !== want.avg[3]
                        || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("mismatch at %0t: want ready=%0d grp=%0d avg=%h %h %h %h last=%0d",
                                     $realtime, want.ready_res, want.grp, want.avg[0],
                                     want.avg[1], want.avg[2], want.avg[3], want.last);
                            $display("                 got  ready=%0d grp=%0d avg=%h %h %h %h last=%0d",
                                     got.ready_res, got.grp, got.avg[0], got.avg[1],
                                     got.avg[2], got.avg[3], got.last);
                        end
                    end
                end
            end
        end
    end

    // no word moving on either side for too long means the block hung
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((price_valid && !price_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
